>>> rtl/ghrs_pkg.sv
// shared types and constants for the heater resistance setpoint pipeline
package ghrs_pkg;

    // transaction payloads
    typedef struct packed {
        logic signed [7:0] ambient_c;
        logic [8:0]        target_c;
    } ghrs_req_t;

    typedef struct packed {
        logic [7:0] setpoint;
        logic       out_of_range;
    } ghrs_rsp_t;

    // register map
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_COEF_G1    = 3'd0;
    localparam logic [2:0] REG_COEF_G2    = 3'd1;
    localparam logic [2:0] REG_COEF_G3    = 3'd2;
    localparam logic [2:0] REG_HEAT_RANGE = 3'd3;
    localparam logic [2:0] REG_HEAT_TRIM  = 3'd4;

    // formula constants
    localparam int unsigned G1_OFFSET   = 784;
    localparam int unsigned G2_OFFSET   = 154009;
    localparam int unsigned B_OFFSET    = 3276800;
    localparam int unsigned TRIM_SCALE  = 131;
    localparam int unsigned E_OFFSET    = 65536;
    localparam int unsigned Q_OFFSET    = 250;
    localparam int unsigned X_SCALE     = 34;
    localparam int unsigned X_ROUND     = 50;

    // reciprocal multipliers for division by constants
    localparam logic [15:0] DIV10_M16  = 16'd52429;       // shift 19, n below 43690
    localparam logic [30:0] DIV100_M31 = 31'd1374389535;  // shift 37, any 32-bit n
    localparam logic [31:0] DIV10_M32  = 32'hCCCCCCCD;    // shift 35, any 32-bit n
    localparam logic [17:0] DIV100_M18 = 18'd167773;      // shift 24, n below 199728

    // reciprocals of heat_range + 4, shift 32, exact for n below 2^29
    localparam logic [30:0] RANGE_RECIP [4] = '{
        31'd1073741824, 31'd858993460, 31'd715827883, 31'd613566757
    };

    // pipeline layout
    localparam int unsigned DIV_BITS   = 11;
    localparam int unsigned DIV_W      = 27;
    localparam int unsigned ST_DIV0    = 9;
    localparam int unsigned ST_F1      = ST_DIV0 + DIV_BITS;
    localparam int unsigned ST_OUT     = ST_F1 + 1;
    localparam int unsigned NUM_STAGES = ST_OUT + 1;

endpackage

>>> rtl/gas_heater_resistance_setpoint.sv
// heater resistance setpoint: pipelined integer formula with apb configuration
// One request transaction enters per cycle unless the pipeline is stalled;
// its response leaves through the 22-stage pipeline, of which eleven stages are
// a restoring divider taking one quotient bit each. Every stage holds its item
// while the next stage is full and stalled, so req_ready follows rsp_ready
// through the chain of stage enables and nothing is dropped or repeated.
// Coefficients and trims sit in apb registers at byte addresses 0 (coef_g1),
// 4 (coef_g2), 8 (coef_g3), 12 (heat_range) and 16 (heat_trim); they reset to
// zero and are to be written only while no transaction is in flight. The
// response carries the low 8 bits of the rounded result and a flag raised when
// the rounded result lies outside 0..255.
module gas_heater_resistance_setpoint
    import ghrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              req_valid,
    output logic              req_ready,
    input  ghrs_req_t         req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ghrs_rsp_t         rsp
);

    // configuration registers
    logic signed [7:0]  coef_g1_reg;
    logic signed [15:0] coef_g2_reg;
    logic signed [7:0]  coef_g3_reg;
    logic [1:0]         heat_range_reg;
    logic signed [7:0]  heat_trim_reg;

    // derived coefficient terms
    logic signed [10:0] g1_wide;
    logic [9:0]         g1_off;
    logic signed [18:0] g2_wide;
    logic [17:0]        g2_off;
    logic signed [17:0] trim_prod;
    logic signed [17:0] e_wide;
    logic [16:0]        heat_e;

    // stage control
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES:0]   en;

    // stage payloads
    logic signed [15:0] s1_ag_reg;
    logic [8:0]         s1_tgt_reg;
    logic [14:0]        ag_mag;
    logic [30:0]        m1;
    logic [11:0]        s2_aq_reg;
    logic               s2_aneg_reg;
    logic [26:0]        s2_p_reg;
    logic signed [20:0] a_mag;
    logic [28:0]        s3_p5_reg;
    logic signed [20:0] s3_a_reg;
    logic [59:0]        m2;
    logic [22:0]        s4_q100_reg;
    logic signed [20:0] s4_a_reg;
    logic [22:0]        s5_n_reg;
    logic signed [20:0] s5_a_reg;
    logic [54:0]        m3;
    logic [19:0]        s6_b0_reg;
    logic signed [20:0] s6_a_reg;
    logic [29:0]        s7_b_reg;
    logic signed [20:0] s7_a_reg;
    logic [30:0]        c_sum;
    logic [28:0]        s8_c_reg;
    logic [58:0]        m4;
    logic [DIV_W-1:0]   div_rem_reg [DIV_BITS+1];
    logic [DIV_BITS-1:0] div_q_reg  [DIV_BITS+1];
    logic [16:0]        x_sum;
    logic               f1_neg_reg;
    logic [15:0]        f1_mag_reg;
    logic [33:0]        m5;
    logic [9:0]         y_mag;
    logic [9:0]         r_val;
    ghrs_rsp_t          rsp_reg;

    // ---------------------------------------------------------------
    // apb configuration port, writes land in the access phase
    // ---------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_g1_reg    <= '0;
            coef_g2_reg    <= '0;
            coef_g3_reg    <= '0;
            heat_range_reg <= '0;
            heat_trim_reg  <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[4:2])
                REG_COEF_G1:    coef_g1_reg    <= pwdata[7:0];
                REG_COEF_G2:    coef_g2_reg    <= pwdata[15:0];
                REG_COEF_G3:    coef_g3_reg    <= pwdata[7:0];
                REG_HEAT_RANGE: heat_range_reg <= pwdata[1:0];
                REG_HEAT_TRIM:  heat_trim_reg  <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    // read back, signed registers sign-extended
    always_comb
    begin
        case (paddr[4:2])
            REG_COEF_G1:    prdata = {{24{coef_g1_reg[7]}}, coef_g1_reg};
            REG_COEF_G2:    prdata = {{16{coef_g2_reg[15]}}, coef_g2_reg};
            REG_COEF_G3:    prdata = {{24{coef_g3_reg[7]}}, coef_g3_reg};
            REG_HEAT_RANGE: prdata = {30'd0, heat_range_reg};
            REG_HEAT_TRIM:  prdata = {{24{heat_trim_reg[7]}}, heat_trim_reg};
            default:        prdata = '0;
        endcase
    end

    // coefficient offsets; all end up positive, so they are kept unsigned
    assign g1_wide   = 11'(coef_g1_reg) + 11'(G1_OFFSET);
    assign g1_off    = g1_wide[9:0];
    assign g2_wide   = 19'(coef_g2_reg) + 19'(G2_OFFSET);
    assign g2_off    = g2_wide[17:0];
    // trim divisor, always between 48768 and 82173
    assign trim_prod = 18'(TRIM_SCALE) * 18'(heat_trim_reg);
    assign e_wide    = trim_prod + 18'(E_OFFSET);
    assign heat_e    = e_wide[16:0];

    // ---------------------------------------------------------------
    // stage enables: a stage loads when empty or when its successor loads
    // ---------------------------------------------------------------
    assign en[NUM_STAGES] = rsp_ready;

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end

    assign req_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= req_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stages 1 to 3: ambient term and target product
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_ag_reg  <= req.ambient_c * coef_g3_reg;
            s1_tgt_reg <= req.target_c;
        end
    end

    // ambient product divided by ten on its magnitude, truncating toward zero
    assign ag_mag = s1_ag_reg[15] ? 15'(-s1_ag_reg) : s1_ag_reg[14:0];
    assign m1     = 31'(ag_mag) * 31'(DIV10_M16);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_aq_reg   <= m1[30:19];
            s2_aneg_reg <= s1_ag_reg[15];
            s2_p_reg    <= 27'(g2_off) * 27'(s1_tgt_reg);
        end
    end

    assign a_mag = 21'({s2_aq_reg, 8'd0});

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_p5_reg <= {s2_p_reg, 2'b00} + 29'(s2_p_reg);
            s3_a_reg  <= s2_aneg_reg ? -a_mag : a_mag;
        end
    end

    // ---------------------------------------------------------------
    // stages 4 to 7: resistance term b
    // ---------------------------------------------------------------
    assign m2 = 60'(s3_p5_reg) * 60'(DIV100_M31);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_q100_reg <= m2[59:37];
            s4_a_reg    <= s3_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_n_reg <= s4_q100_reg + 23'(B_OFFSET);
            s5_a_reg <= s4_a_reg;
        end
    end

    assign m3 = 55'(s5_n_reg) * 55'(DIV10_M32);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s6_b0_reg <= m3[54:35];
            s6_a_reg  <= s5_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s7_b_reg <= 30'(g1_off) * 30'(s6_b0_reg);
            s7_a_reg <= s6_a_reg;
        end
    end

    // ---------------------------------------------------------------
    // stages 8 and 9: c = a + b/2, then divide by the range code plus four
    // c is always positive and below 2^29
    // ---------------------------------------------------------------
    assign c_sum = 31'(s7_a_reg) + 31'(s7_b_reg[29:1]);

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s8_c_reg <= c_sum[28:0];
        end
    end

    assign m4 = 59'(s8_c_reg) * 59'(RANGE_RECIP[heat_range_reg]);

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            div_rem_reg[0] <= m4[58:32];
            div_q_reg[0]   <= '0;
        end
    end

    // ---------------------------------------------------------------
    // restoring divider by the trim term, one quotient bit per stage,
    // quotient always below 2^11
    // ---------------------------------------------------------------
    for (genvar j = 0; j < DIV_BITS; j++)
    begin : g_div
        logic [DIV_W:0] dsh;
        logic [DIV_W:0] diff;
        logic           take;

        assign dsh  = (DIV_W + 1)'(heat_e) << (DIV_BITS - 1 - j);
        assign diff = {1'b0, div_rem_reg[j]} - dsh;
        assign take = !diff[DIV_W];

        always_ff @(posedge clk)
        begin
            if (en[ST_DIV0 + j])
            begin
                div_rem_reg[j+1] <= take ? diff[DIV_W-1:0] : div_rem_reg[j];
                div_q_reg[j+1]   <= {div_q_reg[j][DIV_BITS-2:0], take};
            end
        end
    end

    // ---------------------------------------------------------------
    // final stages: scale, add fifty and divide by hundred truncating toward zero, wrap and flag
    // ---------------------------------------------------------------
    assign x_sum = (17'(div_q_reg[DIV_BITS]) - 17'(Q_OFFSET)) * 17'(X_SCALE)
                   + 17'(X_ROUND);

    always_ff @(posedge clk)
    begin
        if (en[ST_F1])
        begin
            f1_neg_reg <= x_sum[16];
            f1_mag_reg <= x_sum[16] ? 16'(-x_sum) : x_sum[15:0];
        end
    end

    assign m5    = 34'(f1_mag_reg) * 34'(DIV100_M18);
    assign y_mag = m5[33:24];
    assign r_val = f1_neg_reg ? -y_mag : y_mag;

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            rsp_reg.setpoint     <= r_val[7:0];
            rsp_reg.out_of_range <= (f1_neg_reg && (y_mag != 10'd0)) || (y_mag[9:8] != 2'd0);
        end
    end

    assign rsp_valid = v_reg[ST_OUT];
    assign rsp       = rsp_reg;

endmodule
